### sv/n_base_pattern_statistics_unit_defines.svh
// ----------------------------------------------------------------------------
// N base pattern statistics - assertion macros
// Check macros for the block's RTL.
// ----------------------------------------------------------------------------
`ifndef N_BASE_PATTERN_STATISTICS_UNIT_DEFINES_SVH
`define N_BASE_PATTERN_STATISTICS_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NBPS_CHECK(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nbps check failed");

// Next-cycle implication, checked out of reset.
`define NBPS_CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nbps next-cycle check failed");

`endif

### sv/nbps_pkg.sv
// ----------------------------------------------------------------------------
// N base pattern statistics - package
// Types, codes and constants shared by the block's files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbps_pkg;

  localparam int MAX_READ_LEN_DEF  = 64;
  localparam int PATTERN_SLOTS_DEF = 32;
  localparam int COUNT_WIDTH_DEF   = 32;

  localparam int MASK_W  = 64;
  localparam int SIZE_W  = 7;
  localparam int SLOT_W  = 5;
  localparam int CNT_W   = 64;
  localparam int OCNT_W  = 32;
  localparam int TOTN_W  = 48;
  localparam int QSLOT_W = 8;

  localparam logic [7:0]        N_CHAR      = 8'h4E;
  localparam logic [TOTN_W-1:0] TOTAL_N_MAX = {TOTN_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_BASE = 2'd0,
    ACT_POS  = 2'd1,
    ACT_PAT  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_POS     = 2'd1,
    KIND_PAT     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIST,
    ST_POS,
    ST_END,
    ST_SEARCH
  } st_t;

  // Query walking the slot chain
  typedef struct packed {
    logic               vld;
    logic               hit;
    logic               is_new;
    logic [QSLOT_W-1:0] slot;
    logic [MASK_W-1:0]  mask;
    logic [SIZE_W-1:0]  size;
    logic [CNT_W-1:0]   cnt;
  } qry_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [SIZE_W-1:0] n_in_read;
    logic [SLOT_W-1:0] slot;
    logic              slot_is_new;
    logic              table_overflow;
    logic              entry_valid;
    logic [MASK_W-1:0] pattern_mask;
    logic [OCNT_W-1:0] count;
    logic [TOTN_W-1:0] total_n;
    logic [OCNT_W-1:0] reads_with_n;
    logic [OCNT_W-1:0] total_reads;
  } res_t;

endpackage

### sv/nbps_if.sv
// ----------------------------------------------------------------------------
// N base pattern statistics - channel interfaces
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] base;
  logic [5:0] index;

  modport source (output valid, action, base, index, input ready);
  modport sink   (input valid, action, base, index, output ready);
endinterface

interface nbps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [6:0]  n_in_read;
  logic [4:0]  slot;
  logic        slot_is_new;
  logic        table_overflow;
  logic        entry_valid;
  logic [63:0] pattern_mask;
  logic [31:0] count;
  logic [47:0] total_n;
  logic [31:0] reads_with_n;
  logic [31:0] total_reads;

  modport source (output valid, result_kind, n_in_read, slot, slot_is_new, table_overflow,
                  entry_valid, pattern_mask, count, total_n, reads_with_n, total_reads,
                  input ready);
  modport sink   (input valid, result_kind, n_in_read, slot, slot_is_new, table_overflow,
                  entry_valid, pattern_mask, count, total_n, reads_with_n, total_reads,
                  output ready);
endinterface

### sv/nbps_cell.sv
// ----------------------------------------------------------------------------
// N base pattern statistics - pattern slot cell
// Holds one pattern slot; matches or claims it for a passing query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbps_cell #(
  parameter int ML  = nbps_pkg::MAX_READ_LEN_DEF,
  parameter int CW  = nbps_pkg::COUNT_WIDTH_DEF,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nbps_pkg::qry_t              q_in,
  output nbps_pkg::qry_t              q_out,
  output logic                        vld_o,
  output logic [ML-1:0]               mask_o,
  output logic [nbps_pkg::SIZE_W-1:0] size_o,
  output logic [CW-1:0]               cnt_o
);

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  logic                        slot_vld_r, slot_vld_nxt;
  logic [ML-1:0]               slot_mask_r, slot_mask_nxt;
  logic [nbps_pkg::SIZE_W-1:0] slot_size_r, slot_size_nxt;
  logic [CW-1:0]               slot_cnt_r, slot_cnt_nxt;
  nbps_pkg::qry_t              q_r, q_nxt;
  logic                        open_q;

  always_comb begin
    open_q        = q_in.vld && !q_in.hit;
    slot_vld_nxt  = slot_vld_r;
    slot_mask_nxt = slot_mask_r;
    slot_size_nxt = slot_size_r;
    slot_cnt_nxt  = slot_cnt_r;
    q_nxt         = q_in;
    if (open_q && slot_vld_r && slot_size_r == q_in.size &&
        slot_mask_r == q_in.mask[ML-1:0]) begin
      // hit: bump count
      slot_cnt_nxt = (slot_cnt_r == CNT_MAX) ? CNT_MAX : slot_cnt_r + 1'b1;
      q_nxt.hit    = 1'b1;
      q_nxt.slot   = nbps_pkg::QSLOT_W'(IDX);
      q_nxt.cnt    = nbps_pkg::CNT_W'(slot_cnt_nxt);
    end else if (open_q && !slot_vld_r) begin
      // first free slot: claim it
      slot_vld_nxt  = 1'b1;
      slot_mask_nxt = q_in.mask[ML-1:0];
      slot_size_nxt = q_in.size;
      slot_cnt_nxt  = CW'(1);
      q_nxt.hit     = 1'b1;
      q_nxt.is_new  = 1'b1;
      q_nxt.slot    = nbps_pkg::QSLOT_W'(IDX);
      q_nxt.cnt     = nbps_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= 1'b0;
      q_r        <= '0;
    end else begin
      slot_vld_r <= slot_vld_nxt;
      q_r        <= q_nxt;
    end
    slot_mask_r <= slot_mask_nxt;
    slot_size_r <= slot_size_nxt;
    slot_cnt_r  <= slot_cnt_nxt;
  end

  assign q_out  = q_r;
  assign vld_o  = slot_vld_r;
  assign mask_o = slot_mask_r;
  assign size_o = slot_size_r;
  assign cnt_o  = slot_cnt_r;

endmodule

### sv/nbps_hist.sv
// ----------------------------------------------------------------------------
// N base pattern statistics - position histogram
// Per-position N counts in a RAM with one read and one write port and per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbps_hist #(
  parameter int DEPTH = nbps_pkg::MAX_READ_LEN_DEF,
  parameter int CW    = nbps_pkg::COUNT_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [CW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [CW-1:0] wr_data
);

  logic [CW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] ent_vld_r;
  logic [CW-1:0]    rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ent_vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (wr_en) begin
      ent_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/n_base_pattern_statistics_unit.sv
// ----------------------------------------------------------------------------
// N base pattern statistics unit
// Counts N bases per position and tallies distinct per-read N patterns.
// ----------------------------------------------------------------------------
// Reads stream in one base per beat; every read is cfg_wdata bases long
// (0 acts as 1, longer than MAX_READ_LEN acts as MAX_READ_LEN; a write drops
// any partial read). The block works on one beat at a time. An N base reads
// the histogram RAM and then, in ST_HIST, writes the incremented count back.
// The last base of a read passes through ST_END; when the read has an N, its
// mask then walks the chain of slot cells one cell per cycle in ST_SEARCH. A
// position read goes through ST_POS, as the RAM read is registered; a pattern
// read loads its result straight from the slot cells. Each result beat sits
// in an output register and the next input beat is taken once it has left.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "n_base_pattern_statistics_unit_defines.svh"

module n_base_pattern_statistics_unit #(
  parameter int MAX_READ_LEN  = nbps_pkg::MAX_READ_LEN_DEF,
  parameter int PATTERN_SLOTS = nbps_pkg::PATTERN_SLOTS_DEF,
  parameter int COUNT_WIDTH   = nbps_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nbps_in_if.sink    in_if,
  nbps_out_if.source out_if,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  localparam int ML = MAX_READ_LEN;
  localparam int PS = PATTERN_SLOTS;
  localparam int CW = COUNT_WIDTH;
  localparam int LW = $clog2(ML + 1);
  localparam int PW = (ML > 1) ? $clog2(ML) : 1;
  localparam int SW = (PS > 1) ? $clog2(PS) : 1;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  nbps_pkg::st_t state_r, state_nxt;
  logic [LW-1:0] eff_len_r, eff_len_nxt;
  logic [LW-1:0] base_pos_r, base_pos_nxt;
  logic [ML-1:0] mask_r, mask_nxt;
  logic [LW-1:0] tally_r, tally_nxt;
  logic          end_r, end_nxt;
  logic [PW-1:0] hist_addr_r, hist_addr_nxt;
  logic [nbps_pkg::TOTN_W-1:0] tot_n_r, tot_n_nxt;
  logic [CW-1:0] rdn_r, rdn_nxt;
  logic [CW-1:0] rds_r, rds_nxt;
  logic          out_vld_r, out_vld_nxt;
  nbps_pkg::res_t out_r, out_nxt, res;

  logic          in_ready;
  logic          load_out;
  logic [LW-1:0] pos_inc;
  logic [nbps_pkg::TOTN_W:0] n_sum;
  logic [SW-1:0] sel;

  logic          hist_rd_en;
  logic [PW-1:0] hist_rd_addr;
  logic [CW-1:0] hist_rd_data;
  logic          hist_wr_en;
  logic [CW-1:0] hist_wr_data;

  nbps_pkg::qry_t q_head;
  nbps_pkg::qry_t q_link [PS+1];
  logic                        c_vld  [PS];
  logic [ML-1:0]               c_mask [PS];
  logic [nbps_pkg::SIZE_W-1:0] c_size [PS];
  logic [CW-1:0]               c_cnt  [PS];

  // Histogram of N per position
  nbps_hist #(.DEPTH(ML), .CW(CW), .AW(PW)) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (hist_rd_en),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd_data),
    .wr_en   (hist_wr_en),
    .wr_addr (hist_addr_r),
    .wr_data (hist_wr_data)
  );

  // Row of pattern slot cells; the query enters at cell 0 and leaves at the tail
  for (genvar gi = 0; gi < PS; gi++) begin : g_cell
    nbps_cell #(.ML(ML), .CW(CW), .IDX(gi)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .q_in   (q_link[gi]),
      .q_out  (q_link[gi+1]),
      .vld_o  (c_vld[gi]),
      .mask_o (c_mask[gi]),
      .size_o (c_size[gi]),
      .cnt_o  (c_cnt[gi])
    );
  end

  assign q_link[0]    = q_head;
  assign in_ready     = (state_r == nbps_pkg::ST_IDLE) && !out_vld_r;
  assign in_if.ready  = in_ready;
  assign pos_inc      = base_pos_r + 1'b1;
  assign sel          = SW'(in_if.index);
  assign hist_wr_data = (hist_rd_data == CNT_MAX) ? CNT_MAX : hist_rd_data + 1'b1;
  assign n_sum        = {1'b0, tot_n_r} + (nbps_pkg::TOTN_W + 1)'(tally_r);

  always_comb begin
    state_nxt     = state_r;
    eff_len_nxt   = eff_len_r;
    base_pos_nxt  = base_pos_r;
    mask_nxt      = mask_r;
    tally_nxt     = tally_r;
    end_nxt       = end_r;
    hist_addr_nxt = hist_addr_r;
    tot_n_nxt     = tot_n_r;
    rdn_nxt       = rdn_r;
    rds_nxt       = rds_r;
    out_vld_nxt   = out_vld_r;
    out_nxt       = out_r;
    res           = '0;
    load_out      = 1'b0;
    hist_rd_en    = 1'b0;
    hist_rd_addr  = PW'(base_pos_r);
    hist_wr_en    = 1'b0;
    q_head        = '0;

    // drop the result once taken
    if (out_vld_r && out_if.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      nbps_pkg::ST_IDLE: begin
        if (in_if.valid && in_ready) begin
          unique case (nbps_pkg::act_t'(in_if.action))
            nbps_pkg::ACT_BASE: begin
              base_pos_nxt = pos_inc;
              end_nxt      = (pos_inc >= eff_len_r);
              if (in_if.base == nbps_pkg::N_CHAR) begin
                mask_nxt      = mask_r | (ML'(1) << PW'(base_pos_r));
                tally_nxt     = tally_r + 1'b1;
                hist_rd_en    = 1'b1;
                hist_addr_nxt = PW'(base_pos_r);
                state_nxt     = nbps_pkg::ST_HIST;
              end else if (pos_inc >= eff_len_r) begin
                state_nxt = nbps_pkg::ST_END;
              end
            end
            nbps_pkg::ACT_POS: begin
              if (int'(in_if.index) < ML) begin
                hist_rd_en   = 1'b1;
                hist_rd_addr = PW'(in_if.index);
                state_nxt    = nbps_pkg::ST_POS;
              end else begin
                res.result_kind = nbps_pkg::KIND_POS;
                load_out        = 1'b1;
              end
            end
            nbps_pkg::ACT_PAT: begin
              res.result_kind = nbps_pkg::KIND_PAT;
              res.slot        = in_if.index[nbps_pkg::SLOT_W-1:0];
              if (int'(in_if.index) < PS && c_vld[sel]) begin
                res.n_in_read    = c_size[sel];
                res.entry_valid  = 1'b1;
                res.pattern_mask = nbps_pkg::MASK_W'(c_mask[sel]);
                res.count        = nbps_pkg::OCNT_W'(c_cnt[sel]);
              end
              load_out = 1'b1;
            end
            default: ;
          endcase
        end
      end
      nbps_pkg::ST_HIST: begin
        hist_wr_en = 1'b1;
        state_nxt  = end_r ? nbps_pkg::ST_END : nbps_pkg::ST_IDLE;
      end
      nbps_pkg::ST_POS: begin
        res.result_kind = nbps_pkg::KIND_POS;
        res.count       = nbps_pkg::OCNT_W'(hist_rd_data);
        load_out        = 1'b1;
        state_nxt       = nbps_pkg::ST_IDLE;
      end
      nbps_pkg::ST_END: begin
        rds_nxt = (rds_r == CNT_MAX) ? CNT_MAX : rds_r + 1'b1;
        if (tally_r != '0) begin
          rdn_nxt   = (rdn_r == CNT_MAX) ? CNT_MAX : rdn_r + 1'b1;
          tot_n_nxt = (n_sum > {1'b0, nbps_pkg::TOTAL_N_MAX}) ? nbps_pkg::TOTAL_N_MAX :
                      n_sum[nbps_pkg::TOTN_W-1:0];
          // launch the pattern query down the chain
          q_head.vld  = 1'b1;
          q_head.mask = nbps_pkg::MASK_W'(mask_r);
          q_head.size = nbps_pkg::SIZE_W'(tally_r);
          state_nxt   = nbps_pkg::ST_SEARCH;
        end else begin
          res.result_kind = nbps_pkg::KIND_SUMMARY;
          load_out        = 1'b1;
          state_nxt       = nbps_pkg::ST_IDLE;
        end
        base_pos_nxt = '0;
        mask_nxt     = '0;
        tally_nxt    = '0;
        end_nxt      = 1'b0;
      end
      nbps_pkg::ST_SEARCH: begin
        if (q_link[PS].vld) begin
          res.result_kind    = nbps_pkg::KIND_SUMMARY;
          res.n_in_read      = q_link[PS].size;
          res.entry_valid    = 1'b1;
          res.pattern_mask   = q_link[PS].mask;
          res.slot_is_new    = q_link[PS].is_new;
          res.table_overflow = !q_link[PS].hit;
          if (q_link[PS].hit) begin
            res.slot  = q_link[PS].slot[nbps_pkg::SLOT_W-1:0];
            res.count = q_link[PS].cnt[nbps_pkg::OCNT_W-1:0];
          end
          load_out  = 1'b1;
          state_nxt = nbps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nbps_pkg::ST_IDLE;
    endcase

    // length write: drop the partial read, whatever the state
    if (cfg_we) begin
      if (cfg_wdata == 7'd0) begin
        eff_len_nxt = LW'(1);
      end else if (int'(cfg_wdata) > ML) begin
        eff_len_nxt = LW'(ML);
      end else begin
        eff_len_nxt = LW'(cfg_wdata);
      end
      base_pos_nxt = '0;
      mask_nxt     = '0;
      tally_nxt    = '0;
    end

    // every result carries the totals as they stand after the beat
    if (load_out) begin
      out_nxt              = res;
      out_nxt.total_n      = tot_n_nxt;
      out_nxt.reads_with_n = nbps_pkg::OCNT_W'(rdn_nxt);
      out_nxt.total_reads  = nbps_pkg::OCNT_W'(rds_nxt);
      out_vld_nxt          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= nbps_pkg::ST_IDLE;
      eff_len_r  <= LW'(ML);
      base_pos_r <= '0;
      mask_r     <= '0;
      tally_r    <= '0;
      end_r      <= 1'b0;
      tot_n_r    <= '0;
      rdn_r      <= '0;
      rds_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      eff_len_r  <= eff_len_nxt;
      base_pos_r <= base_pos_nxt;
      mask_r     <= mask_nxt;
      tally_r    <= tally_nxt;
      end_r      <= end_nxt;
      tot_n_r    <= tot_n_nxt;
      rdn_r      <= rdn_nxt;
      rds_r      <= rds_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    hist_addr_r <= hist_addr_nxt;
    out_r       <= out_nxt;
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.result_kind    = out_r.result_kind;
  assign out_if.n_in_read      = out_r.n_in_read;
  assign out_if.slot           = out_r.slot;
  assign out_if.slot_is_new    = out_r.slot_is_new;
  assign out_if.table_overflow = out_r.table_overflow;
  assign out_if.entry_valid    = out_r.entry_valid;
  assign out_if.pattern_mask   = out_r.pattern_mask;
  assign out_if.count          = out_r.count;
  assign out_if.total_n        = out_r.total_n;
  assign out_if.reads_with_n   = out_r.reads_with_n;
  assign out_if.total_reads    = out_r.total_reads;

  // A query only leaves the chain while the block waits for it
  `NBPS_CHECK(a_tail_in_search, clk, rst_n, q_link[PS].vld, state_r == nbps_pkg::ST_SEARCH)
  // Between beats the base position stays inside the read
  `NBPS_CHECK(a_pos_in_read, clk, rst_n, state_r == nbps_pkg::ST_IDLE, base_pos_r < eff_len_r)
  // Effective length stays clamped
  `NBPS_CHECK(a_len_range, clk, rst_n, 1'b1, eff_len_r != '0 && int'(eff_len_r) <= ML)
  // Read end bookkeeping runs for a single cycle
  `NBPS_CHECK_NEXT(a_end_once, clk, rst_n, state_r == nbps_pkg::ST_END, state_r != nbps_pkg::ST_END)

endmodule
